[src/spa_pkg.sv]
`timescale 1ns / 1ps

package spa_pkg;

  localparam int MODE_W      = 3;
  localparam int IDX_W       = 9;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 10;
  localparam int LANES       = 32;
  localparam int LANE_W      = 5;
  localparam int SLOT_BITS   = 4;
  localparam int DEF_SLOTS   = 512;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_ALLOC       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_HOLD    = 3'd4;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_DELETE,
    OP_SOFT_DELETE,
    OP_RELEASE,
    OP_SET_HOLD,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_FREE  = 2'd2,
    STAT_DEFER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SINGLE,
    BS_ALLOC,
    BS_RELEASE,
    BS_RESP
  } bstate_t;

  typedef struct packed {
    op_t              op;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             owner;
  } cmd_t;

  typedef struct packed {
    logic owner;
    logic pending;
    logic hold;
    logic active;
  } slot_t;

endpackage

[src/slot_pool_allocator.sv]
// delete, soft delete and set hold read and update the addressed slot; allocate walks the
// slot table ram from row 0 to the first free slot and release walks every row, one row per
// cycle (32 slots per row), ROWS = ceil(SLOTS/32) (16 at 512); new requests are taken into
// the front register and queue while an earlier one is in work
// reset: a clearing pass writes every row of the table, in_ready low meanwhile
`timescale 1ns / 1ps

module slot_pool_allocator #(
  parameter int SLOTS = spa_pkg::DEF_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spa_pkg::MODE_W-1:0]   in_mode,
  input  logic [spa_pkg::IDX_W-1:0]    in_slot_index,
  input  logic                         in_owner,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spa_pkg::IDX_W-1:0]    out_granted_slot,
  output logic [spa_pkg::STATUS_W-1:0] out_status,
  output logic [spa_pkg::COUNT_W-1:0]  out_freed_count
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  logic          clearing;
  spa_pkg::cmd_t q_in;
  spa_pkg::cmd_t q_head;

  spa_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_slot_index (in_slot_index),
    .in_owner      (in_owner),
    .hold_off      (clearing),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full)
  );

  spa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  spa_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_not_empty),
    .cmd              (q_head),
    .cmd_pop          (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .out_freed_count  (out_freed_count)
  );

endmodule

[src/spa_ram.sv]
`timescale 1ns / 1ps

module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/spa_queue.sv]
`timescale 1ns / 1ps

module spa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spa_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output spa_pkg::cmd_t head,
  output logic          not_empty
);

  localparam int DEPTH = spa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(DEPTH);

  spa_pkg::cmd_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue underflow");

endmodule

[src/spa_front.sv]
`timescale 1ns / 1ps

module spa_front #(
  parameter int SLOTS = spa_pkg::DEF_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [spa_pkg::MODE_W-1:0] in_mode,
  input  logic [spa_pkg::IDX_W-1:0]  in_slot_index,
  input  logic                       in_owner,
  input  logic                       hold_off,
  output logic                       q_push,
  output spa_pkg::cmd_t              q_data,
  input  logic                       q_full
);

  logic          valid_r, valid_nxt;
  spa_pkg::cmd_t cmd_r;
  spa_pkg::cmd_t cmd_dec;
  logic          accept;

  assign q_push   = valid_r && !q_full;
  assign in_ready = !hold_off && (!valid_r || !q_full);
  assign accept   = in_valid && in_ready;
  assign q_data   = cmd_r;

  // decode the mode and check the addressed slot against the table size
  always_comb begin
    cmd_dec.idx      = in_slot_index;
    cmd_dec.owner    = in_owner;
    cmd_dec.in_range = (32'(in_slot_index) < 32'(SLOTS));
    unique case (in_mode)
      spa_pkg::MODE_ALLOC:       cmd_dec.op = spa_pkg::OP_ALLOC;
      spa_pkg::MODE_DELETE:      cmd_dec.op = spa_pkg::OP_DELETE;
      spa_pkg::MODE_SOFT_DELETE: cmd_dec.op = spa_pkg::OP_SOFT_DELETE;
      spa_pkg::MODE_RELEASE:     cmd_dec.op = spa_pkg::OP_RELEASE;
      spa_pkg::MODE_SET_HOLD:    cmd_dec.op = spa_pkg::OP_SET_HOLD;
      default:                   cmd_dec.op = spa_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_dec;
    end
  end

endmodule

[src/spa_back.sv]
`timescale 1ns / 1ps

module spa_back #(
  parameter int SLOTS = spa_pkg::DEF_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  spa_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spa_pkg::IDX_W-1:0]    out_granted_slot,
  output logic [spa_pkg::STATUS_W-1:0] out_status,
  output logic [spa_pkg::COUNT_W-1:0]  out_freed_count
);

  localparam int LANES   = spa_pkg::LANES;
  localparam int LW      = spa_pkg::LANE_W;
  localparam int IW      = spa_pkg::IDX_W;
  localparam int CW      = spa_pkg::COUNT_W;
  localparam int ROWS    = (SLOTS + LANES - 1) / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DATA_W  = LANES * spa_pkg::SLOT_BITS;
  localparam int NUM_W   = ROW_W + LW;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  spa_pkg::bstate_t state_r, state_nxt;
  logic [ROW_W-1:0] scan_row_r, scan_row_nxt;
  spa_pkg::cmd_t    cur_r, cur_nxt;
  logic [IW-1:0]    res_slot_r, res_slot_nxt;
  spa_pkg::status_t res_status_r, res_status_nxt;
  logic [CW-1:0]    res_freed_r, res_freed_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IW-1:0]    out_slot_r;
  spa_pkg::status_t out_status_r;
  logic [CW-1:0]    out_freed_r;
  logic             load_out;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  spa_pkg::slot_t [LANES-1:0] row_q;
  spa_pkg::slot_t [LANES-1:0] wrow;
  spa_pkg::slot_t [LANES-1:0] rel_row;

  logic [ROW_W+IW-LW-1:0] cmd_row_ext, cur_row_ext;
  logic [ROW_W-1:0]       cmd_row, cur_row, next_row;
  logic [LW-1:0]          cur_lane;
  spa_pkg::slot_t         cur_slot;
  logic                   cur_used;

  logic [LANES-1:0] free_vec;
  logic [LANES-1:0] rel_vec;
  logic             hit;
  logic [LW-1:0]    hit_lane;
  logic [NUM_W+IW-1:0] hit_num_ext;
  logic [LW:0]      rel_cnt;
  logic [CW:0]      rel_sum;

  spa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wrow),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_q = ram_rdata;

  assign cmd_row_ext = {{ROW_W{1'b0}}, cmd.idx[IW-1:LW]};
  assign cmd_row     = cmd_row_ext[ROW_W-1:0];
  assign cur_row_ext = {{ROW_W{1'b0}}, cur_r.idx[IW-1:LW]};
  assign cur_row     = cur_row_ext[ROW_W-1:0];
  assign cur_lane    = cur_r.idx[LW-1:0];
  assign cur_slot    = row_q[cur_lane];
  assign cur_used    = cur_r.in_range && (cur_slot.active || cur_slot.hold || cur_slot.pending);
  assign next_row    = (scan_row_r == ROW_LAST) ? scan_row_r : scan_row_r + ROW_W'(1);

  // per-lane view of the row currently on the read port
  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    rel_row  = row_q;
    for (int l = 0; l < LANES; l++) begin
      free_vec[l] = !(row_q[l].active || row_q[l].hold || row_q[l].pending) &&
                    (32'({scan_row_r, LW'(l)}) < 32'(SLOTS));
      rel_vec[l]  = row_q[l].active && (row_q[l].owner == cur_r.owner);
      if (rel_vec[l]) begin
        rel_row[l].active  = 1'b0;
        rel_row[l].hold    = 1'b0;
        rel_row[l].pending = 1'b0;
      end
    end
    for (int l = LANES - 1; l >= 0; l--) begin
      if (free_vec[l]) begin
        hit      = 1'b1;
        hit_lane = LW'(l);
      end
    end
  end

  assign hit_num_ext = {{IW{1'b0}}, scan_row_r, hit_lane};
  assign rel_cnt     = (LW + 1)'($countones(rel_vec));
  assign rel_sum     = {1'b0, res_freed_r} + (CW + 1)'(rel_cnt);

  always_comb begin
    state_nxt      = state_r;
    scan_row_nxt   = scan_row_r;
    cur_nxt        = cur_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_freed_nxt  = res_freed_r;
    ram_we         = 1'b0;
    ram_waddr      = scan_row_r;
    ram_raddr      = scan_row_r;
    wrow           = row_q;
    cmd_pop        = 1'b0;
    load_out       = 1'b0;
    unique case (state_r)
      spa_pkg::BS_CLEAR: begin
        ram_we = 1'b1;
        wrow   = '0;
        if (scan_row_r == ROW_LAST) begin
          scan_row_nxt = '0;
          state_nxt    = spa_pkg::BS_IDLE;
        end else begin
          scan_row_nxt = scan_row_r + ROW_W'(1);
        end
      end
      spa_pkg::BS_IDLE: begin
        scan_row_nxt = '0;
        ram_raddr    = (cmd.op == spa_pkg::OP_ALLOC || cmd.op == spa_pkg::OP_RELEASE) ?
                       '0 : cmd_row;
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cur_nxt        = cmd;
          res_slot_nxt   = cmd.idx;
          res_status_nxt = spa_pkg::STAT_DONE;
          res_freed_nxt  = '0;
          unique case (cmd.op)
            spa_pkg::OP_ALLOC:       state_nxt = spa_pkg::BS_ALLOC;
            spa_pkg::OP_RELEASE:     state_nxt = spa_pkg::BS_RELEASE;
            spa_pkg::OP_DELETE,
            spa_pkg::OP_SOFT_DELETE,
            spa_pkg::OP_SET_HOLD:    state_nxt = spa_pkg::BS_SINGLE;
            default:                 state_nxt = spa_pkg::BS_RESP;
          endcase
        end
      end
      spa_pkg::BS_SINGLE: begin
        ram_waddr = cur_row;
        state_nxt = spa_pkg::BS_RESP;
        if (!cur_used) begin
          res_status_nxt = spa_pkg::STAT_FREE;
        end else begin
          unique case (cur_r.op)
            spa_pkg::OP_DELETE: begin
              ram_we                 = 1'b1;
              wrow[cur_lane].active  = 1'b0;
              wrow[cur_lane].hold    = 1'b0;
              wrow[cur_lane].pending = 1'b0;
              res_freed_nxt          = CW'(1);
            end
            spa_pkg::OP_SOFT_DELETE: begin
              ram_we = 1'b1;
              if (cur_slot.hold) begin
                wrow[cur_lane].pending = 1'b1;
                res_status_nxt         = spa_pkg::STAT_DEFER;
              end else begin
                wrow[cur_lane].active  = 1'b0;
                wrow[cur_lane].hold    = 1'b0;
                wrow[cur_lane].pending = 1'b0;
                res_freed_nxt          = CW'(1);
              end
            end
            spa_pkg::OP_SET_HOLD: begin
              ram_we              = 1'b1;
              wrow[cur_lane].hold = 1'b1;
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
      end
      spa_pkg::BS_ALLOC: begin
        ram_raddr = next_row;
        if (hit) begin
          ram_we                 = 1'b1;
          wrow[hit_lane].owner   = cur_r.owner;
          wrow[hit_lane].active  = 1'b1;
          wrow[hit_lane].hold    = 1'b0;
          wrow[hit_lane].pending = 1'b0;
          res_slot_nxt           = hit_num_ext[IW-1:0];
          state_nxt              = spa_pkg::BS_RESP;
        end else if (scan_row_r == ROW_LAST) begin
          res_slot_nxt   = '0;
          res_status_nxt = spa_pkg::STAT_FULL;
          state_nxt      = spa_pkg::BS_RESP;
        end else begin
          scan_row_nxt = next_row;
        end
      end
      spa_pkg::BS_RELEASE: begin
        ram_raddr     = next_row;
        ram_we        = 1'b1;
        wrow          = rel_row;
        res_freed_nxt = (rel_sum > (CW + 1)'(spa_pkg::COUNT_MAX)) ?
                        spa_pkg::COUNT_MAX : rel_sum[CW-1:0];
        if (scan_row_r == ROW_LAST) begin
          state_nxt = spa_pkg::BS_RESP;
        end else begin
          scan_row_nxt = next_row;
        end
      end
      spa_pkg::BS_RESP: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = spa_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = spa_pkg::BS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spa_pkg::BS_CLEAR;
      scan_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_row_r  <= scan_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_freed_r  <= res_freed_nxt;
    if (load_out) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
      out_freed_r  <= res_freed_r;
    end
  end

  assign clearing         = (state_r == spa_pkg::BS_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;
  assign out_freed_count  = out_freed_r;

  a_clear_covers_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spa_pkg::BS_CLEAR && state_nxt == spa_pkg::BS_IDLE) |->
      scan_row_r == ROW_LAST)
    else $error("clearing pass ended early");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == spa_pkg::BS_RESP)
    else $error("result loaded outside response state");

endmodule
